@@ rtl/mal_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mal_pkg
// Types and constants shared by the multicast address list modules.
// ----------------------------------------------------------------------------
package mal_pkg;

   localparam int ADDR_W        = 48;
   localparam int COUNT_FIELD_W = 5;

   // request operation codes
   localparam logic MODE_ADD    = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   // response status codes
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef struct packed {
      logic              mode;
      logic [ADDR_W-1:0] address;
   } req_payload_type;

   typedef struct packed {
      logic                     status;
      logic [COUNT_FIELD_W-1:0] entry_count;
      logic                     pass_all_multicast;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_RESP
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;     // capture request, clear index
      logic write_add;    // write request address at end of list
      logic rd_en;        // read table
      logic rd_next;      // read at index + 1 instead of index
      logic write_shift;  // write read data at index
      logic idx_inc;
      logic count_inc;
      logic count_dec;
      logic set_flag;
      logic set_status;
      logic status_value;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_remove;
      logic full;
      logic empty;
      logic match;
      logic idx_last;     // index + 1 reaches count
      logic idx_last2;    // index + 2 reaches count
   } dp_status_type;

endpackage

@@ rtl/multicast_address_list.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multicast_address_list
// Bounded ordered list of 48-bit multicast addresses with add and remove.
//
//   channel   ports                      direction  handshake
//   request   start, busy, req_payload   in         start & !busy
//   response  rsp_strobe, rsp_payload    out        rsp_strobe, one cycle
//
// An add passes through the decode state to the response state, which raises
// the strobe. A remove reads the table one entry at a time through a single
// registered read port, first to find the match and then to move later
// entries down. The block is idle again in the cycle after the strobe.
// Synchronous reset clears the count and the flag; table contents are
// undefined until written. The response cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module multicast_address_list #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  mal_pkg::req_payload_type req_payload,
   output logic                     rsp_strobe,
   output mal_pkg::rsp_payload_type rsp_payload
);
   import mal_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type stat;

   mal_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .stat       (stat),
      .cmd        (cmd)
   );

   mal_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ rtl/mal_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mal_datapath
// Address table, entry count, sticky flag, index counter and response fields.
// ----------------------------------------------------------------------------
module mal_datapath #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mal_pkg::req_payload_type req_payload,
   input  mal_pkg::dp_cmd_type      cmd,
   output mal_pkg::dp_status_type   stat,
   output mal_pkg::rsp_payload_type rsp_payload
);
   import mal_pkg::*;

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic [ADDR_W-1:0] mem [TABLE_DEPTH];
   logic [ADDR_W-1:0] rd_data_ff;
   req_payload_type   req_ff;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic              flag_ff, flag_in;
   logic              status_ff, status_in;
   logic [CW:0]       idx_plus1;
   logic [CW:0]       idx_plus2;
   logic [IW-1:0]     rd_addr;
   logic [IW-1:0]     wr_addr;
   logic [ADDR_W-1:0] wr_data;
   logic              wr_en;

   assign idx_plus1 = {1'b0, idx_ff} + (CW+1)'(1);
   assign idx_plus2 = {1'b0, idx_ff} + (CW+1)'(2);

   // table access
   assign rd_addr = cmd.rd_next ? idx_plus1[IW-1:0] : idx_ff[IW-1:0];
   assign wr_addr = cmd.write_add ? count_ff[IW-1:0] : idx_ff[IW-1:0];
   assign wr_data = cmd.write_add ? req_ff.address : rd_data_ff;
   assign wr_en   = cmd.write_add | cmd.write_shift;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_payload;
      end
   end

   // next values of control registers
   always_comb begin
      count_in  = count_ff;
      idx_in    = idx_ff;
      flag_in   = flag_ff;
      status_in = status_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end
      if (cmd.load_req) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_plus1[CW-1:0];
      end
      if (cmd.set_flag) begin
         flag_in = 1'b1;
      end
      if (cmd.set_status) begin
         status_in = cmd.status_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         idx_ff    <= '0;
         flag_ff   <= 1'b0;
         status_ff <= STATUS_OK;
      end else begin
         count_ff  <= count_in;
         idx_ff    <= idx_in;
         flag_ff   <= flag_in;
         status_ff <= status_in;
      end
   end

   // status towards the controller
   always_comb begin
      stat.is_remove = (req_ff.mode == MODE_REMOVE);
      stat.full      = (count_ff == CW'(TABLE_DEPTH));
      stat.empty     = (count_ff == '0);
      stat.match     = (rd_data_ff == req_ff.address);
      stat.idx_last  = (idx_plus1 >= {1'b0, count_ff});
      stat.idx_last2 = (idx_plus2 >= {1'b0, count_ff});
   end

   // response fields
   always_comb begin
      rsp_payload.status             = status_ff;
      rsp_payload.entry_count        = COUNT_FIELD_W'(count_ff);
      rsp_payload.pass_all_multicast = flag_ff;
   end

endmodule

@@ rtl/mal_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mal_ctrl
// Sequencer for add, search and compaction over the address table.
// ----------------------------------------------------------------------------
module mal_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output logic                   rsp_strobe,
   input  mal_pkg::dp_status_type stat,
   output mal_pkg::dp_cmd_type    cmd
);
   import mal_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (stat.is_remove && !stat.empty) begin
               state_in = ST_SRCH_RD;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_SRCH_RD: state_in = ST_SRCH_CMP;
         ST_SRCH_CMP: begin
            if (stat.match && !stat.idx_last) begin
               state_in = ST_SHIFT_RD;
            end else if (stat.match || stat.idx_last) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_SRCH_RD;
            end
         end
         ST_SHIFT_RD: state_in = ST_SHIFT_WR;
         ST_SHIFT_WR: begin
            if (stat.idx_last2) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_SHIFT_RD;
            end
         end
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      busy       = (state_ff != ST_IDLE);
      rsp_strobe = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load_req = start;
         end
         ST_DECODE: begin
            if (!stat.is_remove) begin
               // add: flag is set whether or not there is room
               cmd.set_flag     = 1'b1;
               cmd.set_status   = 1'b1;
               cmd.status_value = stat.full ? STATUS_REJECT : STATUS_OK;
               cmd.write_add    = !stat.full;
               cmd.count_inc    = !stat.full;
            end else if (stat.empty) begin
               cmd.set_status   = 1'b1;
               cmd.status_value = STATUS_REJECT;
            end
         end
         ST_SRCH_RD: begin
            cmd.rd_en = 1'b1;
         end
         ST_SRCH_CMP: begin
            if (stat.match) begin
               if (stat.idx_last) begin
                  // match on last entry: nothing to move
                  cmd.count_dec    = 1'b1;
                  cmd.set_status   = 1'b1;
                  cmd.status_value = STATUS_OK;
               end
            end else begin
               cmd.idx_inc = 1'b1;
               if (stat.idx_last) begin
                  cmd.set_status   = 1'b1;
                  cmd.status_value = STATUS_REJECT;
               end
            end
         end
         ST_SHIFT_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_next = 1'b1;
         end
         ST_SHIFT_WR: begin
            cmd.write_shift = 1'b1;
            cmd.idx_inc     = 1'b1;
            if (stat.idx_last2) begin
               cmd.count_dec    = 1'b1;
               cmd.set_status   = 1'b1;
               cmd.status_value = STATUS_OK;
            end
         end
         ST_RESP: begin
            rsp_strobe = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ tb/sv/tb_multicast_address_list.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multicast_address_list
// Self-checking testbench for the multicast address list. Requests are sent
// through the start/busy handshake. A shadow copy of the list, its count and
// the sticky pass-all flag predicts every response, which is then compared
// field by field when its strobe arrives. Directed requests cover the empty
// and full list, the extreme addresses and duplicate removal. Random traffic
// then runs in three phases with different sender gaps.
// ----------------------------------------------------------------------------
module tb_multicast_address_list;

   import mal_pkg::*;

   localparam int TABLE_DEPTH   = 16;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 40;
   localparam int MAX_REPORTS   = 10;
   localparam int POOL_SIZE     = 8;

   localparam logic [ADDR_W-1:0] ADDR_ZERO   = '0;
   localparam logic [ADDR_W-1:0] ADDR_ONES   = '1;
   localparam logic [ADDR_W-1:0] ADDR_ABSENT = 48'h0155_5555_5555;
   localparam logic [ADDR_W-1:0] ADDR_DUP    = 48'h0100_5E00_0001;
   localparam logic [ADDR_W-1:0] ADDR_UNIQUE = 48'h3333_0000_0000;

   logic            clock = 1'b0;
   logic            reset;
   logic            start;
   logic            busy;
   req_payload_type req_payload;
   logic            rsp_strobe;
   rsp_payload_type rsp_payload;

   // shadow of the list held by the block
   logic [ADDR_W-1:0] shadow_addr [TABLE_DEPTH];
   int                shadow_count;
   logic              shadow_flag;

   logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
   rsp_payload_type   expected_responses [$];
   rsp_payload_type   expected_head;
   int                mismatch_count;
   int                cycle_count;

   multicast_address_list #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run time guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // apply one request to the shadow list and return the response it gives
   function automatic rsp_payload_type apply_list_update(input logic op,
                                                        input logic [ADDR_W-1:0] addr);
      rsp_payload_type rsp;
      int              hit;
      rsp.status = STATUS_REJECT;
      if (op == MODE_ADD) begin
         // every add sets the flag, even a rejected one
         shadow_flag = 1'b1;
         if (shadow_count < TABLE_DEPTH) begin
            shadow_addr[shadow_count] = addr;
            shadow_count++;
            rsp.status = STATUS_OK;
         end
      end else begin
         // first match only; later entries move down one place
         hit = -1;
         for (int k = 0; k < shadow_count; k++)
            if (hit < 0 && shadow_addr[k] == addr) hit = k;
         if (hit >= 0) begin
            for (int k = hit; k + 1 < shadow_count; k++)
               shadow_addr[k] = shadow_addr[k + 1];
            shadow_count--;
            rsp.status = STATUS_OK;
         end
      end
      rsp.entry_count        = COUNT_FIELD_W'(shadow_count);
      rsp.pass_all_multicast = shadow_flag;
      return rsp;
   endfunction

   function automatic logic [ADDR_W-1:0] random_address();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[ADDR_W-1:0];
   endfunction

   // removes mostly hit a live entry so that shifts happen often
   function automatic logic [ADDR_W-1:0] pick_address(input logic op);
      int sel;
      sel = $urandom_range(0, 99);
      if (op == MODE_REMOVE && shadow_count > 0 && sel < 70)
         return shadow_addr[$urandom_range(0, shadow_count - 1)];
      if (sel < 85)
         return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      return random_address();
   endfunction

   // called at a rising edge; returns at the edge that accepts the request
   task automatic send_request(input logic op, input logic [ADDR_W-1:0] addr);
      req_payload_type req;
      req.mode    = op;
      req.address = addr;
      start       <= 1'b1;
      req_payload <= req;
      do @(posedge clock); while (busy);
      expected_responses.push_back(apply_list_update(op, addr));
   endtask

   // random sender gap, with noise on the payload while start is low
   task automatic idle_before_request(input int idle_pct);
      while ($urandom_range(0, 99) < idle_pct) begin
         start       <= 1'b0;
         req_payload <= {1'($urandom), random_address()};
         @(posedge clock);
      end
   endtask

   task automatic wait_for_responses();
      start <= 1'b0;
      while (expected_responses.size() != 0) @(posedge clock);
   endtask

   // empty list, extreme addresses, remove of the head and a missing address
   task automatic test_empty_and_extremes();
      send_request(MODE_REMOVE, ADDR_ONES);
      send_request(MODE_ADD, ADDR_ZERO);
      send_request(MODE_ADD, ADDR_ONES);
      send_request(MODE_REMOVE, ADDR_ZERO);
      send_request(MODE_REMOVE, ADDR_ABSENT);
   endtask

   // fill to capacity with duplicates, then one add too many
   task automatic test_fill_and_overflow();
      for (int i = 0; i < TABLE_DEPTH - 1; i++)
         send_request(MODE_ADD, (i % 3 == 0) ? ADDR_DUP : ADDR_UNIQUE + i);
      send_request(MODE_ADD, ADDR_ONES);
   endtask

   // duplicate removal takes the first match; then remove the tail entry
   task automatic test_duplicate_removal();
      send_request(MODE_REMOVE, ADDR_DUP);
      send_request(MODE_REMOVE, ADDR_UNIQUE + TABLE_DEPTH - 2);
      wait_for_responses();
   endtask

   // add bias is redrawn every 40 requests so the list swings between empty and full
   task automatic test_random_traffic(input int idle_pct, input int n_items);
      int                add_pct;
      logic              op;
      logic [ADDR_W-1:0] addr;
      for (int i = 0; i < n_items; i++) begin
         if (i % 40 == 0) begin
            case ($urandom_range(0, 2))
               0:       add_pct = 25;
               1:       add_pct = 50;
               default: add_pct = 80;
            endcase
         end
         op   = ($urandom_range(0, 99) < add_pct) ? MODE_ADD : MODE_REMOVE;
         addr = pick_address(op);
         idle_before_request(idle_pct);
         send_request(op, addr);
      end
      wait_for_responses();
   endtask

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_responses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected response: status %0d count %0d flag %0d",
                        rsp_payload.status, rsp_payload.entry_count,
                        rsp_payload.pass_all_multicast);
         end else begin
            expected_head = expected_responses.pop_front();
            if (rsp_payload.status !== expected_head.status ||
                rsp_payload.entry_count !== expected_head.entry_count ||
                rsp_payload.pass_all_multicast !== expected_head.pass_all_multicast) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("mismatch at %0t: status %0d/%0d count %0d/%0d flag %0d/%0d (exp/act)",
                           $realtime, expected_head.status, rsp_payload.status,
                           expected_head.entry_count, rsp_payload.entry_count,
                           expected_head.pass_all_multicast,
                           rsp_payload.pass_all_multicast);
            end
         end
      end
   end

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_payload    = '0;
      shadow_count   = 0;
      shadow_flag    = 1'b0;
      addr_pool[0]   = ADDR_ZERO;
      addr_pool[1]   = ADDR_ONES;
      for (int k = 2; k < POOL_SIZE; k++)
         addr_pool[k] = random_address() | 48'h0100_0000_0000;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_and_extremes();
      test_fill_and_overflow();
      test_duplicate_removal();
      test_random_traffic(8, 383);
      test_random_traffic(81, 383);
      test_random_traffic(0, 384);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_responses.size() != 0)
         $display("%0d responses never arrived", expected_responses.size());
      if (mismatch_count == 0 && expected_responses.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
